// ===== hdl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, constants, types and the output saturation function for the
// quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int IN_W   = 16;             // Q1.14 component
    localparam int PROD_W = 2 * IN_W;       // raw product
    localparam int D_W    = PROD_W + 2;     // divisor (norm squared), signed
    localparam int NUM_W  = PROD_W + 3;     // matrix numerator, signed
    localparam int N_W    = NUM_W + 16;     // numerator * 2^16 + d
    localparam int MAG_W  = PROD_W + 17;    // |n| while normalizing
    localparam int DD_W   = D_W;            // 2 * d
    localparam int QW     = 17;             // quotient bits
    localparam int TRIAL_W = DD_W + QW - 1; // shifted divisor
    localparam int OUT_W  = 18;             // Q2.15 entry
    localparam int SAT_W  = NUM_W + 1;
    localparam int LANES  = 9;

    localparam logic signed [D_W-1:0]   ONE_PROD = D_W'(268435456);
    localparam logic signed [OUT_W-1:0] ONE_Q15  = OUT_W'(32768);
    localparam logic signed [SAT_W-1:0] OUT_MAX  = SAT_W'(131071);
    localparam logic signed [SAT_W-1:0] OUT_MIN  = -SAT_W'(131072);
    localparam logic signed [SAT_W-1:0] BYP_HALF = SAT_W'(4096);
    localparam int BYP_SH = 13;

    typedef struct packed {
        logic valid;
        logic zero;
        logic norm;
    } qrm_ctrl_t;

    typedef struct packed {
        logic [MAG_W-1:0]        rem;
        logic [QW-1:0]           quot;
        logic [DD_W-1:0]         dd;
        logic                    neg;
        logic signed [OUT_W-1:0] byp;
    } qrm_div_t;

    function automatic logic signed [OUT_W-1:0] sat_q215(input logic signed [SAT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/quaternion_to_rotation_matrix_unit.sv =====
// Pipeline: 22 register stages from request acceptance to m_valid
// (4 front, 17 divider at one quotient bit each, 1 output; the first loads at the accepting edge).
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and m_ready is low.
// Reset (aresetn low, synchronous): all valid bits clear, normalize_enable = 1.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Converts a Q1.14 quaternion to a saturated Q2.15 3x3 rotation matrix,
// optionally normalizing by the squared norm.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [qrm_pkg::IN_W-1:0]  s_quat_w,
    input  logic signed [qrm_pkg::IN_W-1:0]  s_quat_x,
    input  logic signed [qrm_pkg::IN_W-1:0]  s_quat_y,
    input  logic signed [qrm_pkg::IN_W-1:0]  s_quat_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m00,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m01,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m02,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m10,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m11,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m12,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m20,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m21,
    output logic signed [qrm_pkg::OUT_W-1:0] m_m22,
    output logic                             m_zero_norm
);

    logic                    en;
    logic                    norm_en_reg;
    logic                    out_valid_reg;
    logic                    zero_reg;
    qrm_pkg::qrm_ctrl_t      ctrl_q [qrm_pkg::QW+1];
    qrm_pkg::qrm_div_t       lane_in [qrm_pkg::LANES];
    logic [qrm_pkg::QW-1:0]  quot [qrm_pkg::LANES];
    logic                    rem_nz [qrm_pkg::LANES];
    logic                    neg [qrm_pkg::LANES];
    logic signed [qrm_pkg::OUT_W-1:0] byp [qrm_pkg::LANES];
    logic signed [qrm_pkg::OUT_W-1:0] mat_reg [qrm_pkg::LANES];
    logic signed [qrm_pkg::OUT_W-1:0] mat_next [qrm_pkg::LANES];

    // advance everything unless a finished result is held
    assign en = m_ready || !out_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            norm_en_reg <= cfg_wr_data;
        end
    end

    qrm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .norm_en  (norm_en_reg),
        .quat_w   (s_quat_w),
        .quat_x   (s_quat_x),
        .quat_y   (s_quat_y),
        .quat_z   (s_quat_z),
        .ctrl_out (ctrl_q[0]),
        .lane_out (lane_in)
    );

    for (genvar i = 0; i < qrm_pkg::LANES; i++) begin : g_lane
        qrm_div u_div (
            .aclk   (aclk),
            .en     (en),
            .din    (lane_in[i]),
            .quot   (quot[i]),
            .rem_nz (rem_nz[i]),
            .neg    (neg[i]),
            .byp    (byp[i])
        );
    end

    // control travels alongside the divider stages
    for (genvar k = 0; k < qrm_pkg::QW; k++) begin : g_ctrl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_q[k+1] <= '0;
            end else if (en) begin
                ctrl_q[k+1] <= ctrl_q[k];
            end
        end
    end

    // floor division sign fix: negative with remainder rounds down one more
    always_comb begin
        logic signed [qrm_pkg::OUT_W-1:0] q;
        logic signed [qrm_pkg::OUT_W-1:0] qs;
        for (int i = 0; i < qrm_pkg::LANES; i++) begin
            q = $signed({1'b0, quot[i]});
            if (!neg[i]) begin
                qs = q;
            end else if (rem_nz[i]) begin
                qs = ~q;
            end else begin
                qs = -q;
            end
            if (ctrl_q[qrm_pkg::QW].zero) begin
                mat_next[i] = (i % 4 == 0) ? qrm_pkg::ONE_Q15 : '0;
            end else if (ctrl_q[qrm_pkg::QW].norm) begin
                mat_next[i] = qs;
            end else begin
                mat_next[i] = byp[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= ctrl_q[qrm_pkg::QW].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg  <= mat_next;
            zero_reg <= ctrl_q[qrm_pkg::QW].zero;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_zero_norm = zero_reg;
    assign m_m00 = mat_reg[0];
    assign m_m01 = mat_reg[1];
    assign m_m02 = mat_reg[2];
    assign m_m10 = mat_reg[3];
    assign m_m11 = mat_reg[4];
    assign m_m12 = mat_reg[5];
    assign m_m20 = mat_reg[6];
    assign m_m21 = mat_reg[7];
    assign m_m22 = mat_reg[8];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> m_m00 == qrm_pkg::ONE_Q15 && m_m11 == qrm_pkg::ONE_Q15
            && m_m22 == qrm_pkg::ONE_Q15 && m_m01 == '0 && m_m12 == '0 && m_m20 == '0)
        else $error("zero quaternion did not give identity");

    a_zero_needs_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_q[qrm_pkg::QW].valid && ctrl_q[qrm_pkg::QW].zero |-> ctrl_q[qrm_pkg::QW].norm)
        else $error("zero flag without normalization");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(ctrl_q[qrm_pkg::QW]) && $stable(ctrl_q[0]))
        else $error("pipeline moved during stall");

endmodule

// ===== hdl/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front
// Input register, products, norm and numerators, then divider operand prep.
// Four register stages; advances when en is high.
// ----------------------------------------------------------------------------
module qrm_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic                                 norm_en,
    input  logic signed [qrm_pkg::IN_W-1:0]      quat_w,
    input  logic signed [qrm_pkg::IN_W-1:0]      quat_x,
    input  logic signed [qrm_pkg::IN_W-1:0]      quat_y,
    input  logic signed [qrm_pkg::IN_W-1:0]      quat_z,
    output qrm_pkg::qrm_ctrl_t                   ctrl_out,
    output qrm_pkg::qrm_div_t                    lane_out [qrm_pkg::LANES]
);

    qrm_pkg::qrm_ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    qrm_pkg::qrm_ctrl_t ctrl3_next;

    logic signed [qrm_pkg::IN_W-1:0]   w1_reg, x1_reg, y1_reg, z1_reg;
    logic signed [qrm_pkg::PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qrm_pkg::PROD_W-1:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic signed [qrm_pkg::D_W-1:0]    d3_reg, d3_next, sumsq;
    logic signed [qrm_pkg::NUM_W-1:0]  num3_reg [qrm_pkg::LANES];
    logic signed [qrm_pkg::NUM_W-1:0]  num3_next [qrm_pkg::LANES];
    qrm_pkg::qrm_div_t                 lane4_reg [qrm_pkg::LANES];
    qrm_pkg::qrm_div_t                 lane4_next [qrm_pkg::LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
        end else if (en) begin
            ctrl1_reg <= '{valid: in_valid, zero: 1'b0, norm: norm_en};
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl3_next;
            ctrl4_reg <= ctrl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= quat_w;
            x1_reg <= quat_x;
            y1_reg <= quat_y;
            z1_reg <= quat_z;
            ww_reg <= w1_reg * w1_reg;
            xx_reg <= x1_reg * x1_reg;
            yy_reg <= y1_reg * y1_reg;
            zz_reg <= z1_reg * z1_reg;
            xy_reg <= x1_reg * y1_reg;
            xz_reg <= x1_reg * z1_reg;
            yz_reg <= y1_reg * z1_reg;
            xw_reg <= x1_reg * w1_reg;
            yw_reg <= y1_reg * w1_reg;
            zw_reg <= z1_reg * w1_reg;
            d3_reg <= d3_next;
            num3_reg <= num3_next;
            lane4_reg <= lane4_next;
        end
    end

    // norm, numerators
    always_comb begin
        sumsq = qrm_pkg::D_W'(ww_reg) + qrm_pkg::D_W'(xx_reg)
              + qrm_pkg::D_W'(yy_reg) + qrm_pkg::D_W'(zz_reg);
        d3_next = ctrl2_reg.norm ? sumsq : qrm_pkg::ONE_PROD;
        ctrl3_next = ctrl2_reg;
        ctrl3_next.zero = ctrl2_reg.norm && (sumsq == '0);
        num3_next[0] = qrm_pkg::NUM_W'(d3_next)
                     - ((qrm_pkg::NUM_W'(yy_reg) + qrm_pkg::NUM_W'(zz_reg)) <<< 1);
        num3_next[1] = (qrm_pkg::NUM_W'(xy_reg) - qrm_pkg::NUM_W'(zw_reg)) <<< 1;
        num3_next[2] = (qrm_pkg::NUM_W'(xz_reg) + qrm_pkg::NUM_W'(yw_reg)) <<< 1;
        num3_next[3] = (qrm_pkg::NUM_W'(xy_reg) + qrm_pkg::NUM_W'(zw_reg)) <<< 1;
        num3_next[4] = qrm_pkg::NUM_W'(d3_next)
                     - ((qrm_pkg::NUM_W'(xx_reg) + qrm_pkg::NUM_W'(zz_reg)) <<< 1);
        num3_next[5] = (qrm_pkg::NUM_W'(yz_reg) - qrm_pkg::NUM_W'(xw_reg)) <<< 1;
        num3_next[6] = (qrm_pkg::NUM_W'(xz_reg) - qrm_pkg::NUM_W'(yw_reg)) <<< 1;
        num3_next[7] = (qrm_pkg::NUM_W'(yz_reg) + qrm_pkg::NUM_W'(xw_reg)) <<< 1;
        num3_next[8] = qrm_pkg::NUM_W'(d3_next)
                     - ((qrm_pkg::NUM_W'(xx_reg) + qrm_pkg::NUM_W'(yy_reg)) <<< 1);
    end

    // divider operands: magnitude of num*2^16 + d, divisor 2d, and the
    // unnormalized result (d = 1.0 makes the division a rounding shift)
    always_comb begin
        logic signed [qrm_pkg::N_W-1:0]   n;
        logic signed [qrm_pkg::N_W-1:0]   n_abs;
        logic signed [qrm_pkg::SAT_W-1:0] t;
        for (int i = 0; i < qrm_pkg::LANES; i++) begin
            n = $signed({num3_reg[i], 16'b0}) + qrm_pkg::N_W'(d3_reg);
            n_abs = n[qrm_pkg::N_W-1] ? -n : n;
            t = (qrm_pkg::SAT_W'(num3_reg[i]) + qrm_pkg::BYP_HALF) >>> qrm_pkg::BYP_SH;
            lane4_next[i].rem  = n_abs[qrm_pkg::MAG_W-1:0];
            lane4_next[i].quot = '0;
            lane4_next[i].dd   = {d3_reg[qrm_pkg::D_W-2:0], 1'b0};
            lane4_next[i].neg  = n[qrm_pkg::N_W-1];
            lane4_next[i].byp  = qrm_pkg::sat_q215(t);
        end
    end

    assign ctrl_out = ctrl4_reg;
    assign lane_out = lane4_reg;

endmodule

// ===== hdl/qrm_div.sv =====
// ----------------------------------------------------------------------------
// qrm_div
// One divider lane: restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qrm_div (
    input  logic                            aclk,
    input  logic                            en,
    input  qrm_pkg::qrm_div_t               din,
    output logic [qrm_pkg::QW-1:0]          quot,
    output logic                            rem_nz,
    output logic                            neg,
    output logic signed [qrm_pkg::OUT_W-1:0] byp
);

    qrm_pkg::qrm_div_t st [qrm_pkg::QW+1];

    assign st[0] = din;

    for (genvar k = 0; k < qrm_pkg::QW; k++) begin : g_stage
        localparam int SH = qrm_pkg::QW - 1 - k;
        logic [qrm_pkg::TRIAL_W-1:0] trial;
        logic                        ge;
        qrm_pkg::qrm_div_t           st_next;

        always_comb begin
            trial = qrm_pkg::TRIAL_W'(st[k].dd) << SH;
            ge = qrm_pkg::TRIAL_W'(st[k].rem) >= trial;
            st_next = st[k];
            if (ge) begin
                st_next.rem = st[k].rem - trial[qrm_pkg::MAG_W-1:0];
                st_next.quot[SH] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st[k+1] <= st_next;
            end
        end
    end

    assign quot   = st[qrm_pkg::QW].quot;
    assign rem_nz = |st[qrm_pkg::QW].rem;
    assign neg    = st[qrm_pkg::QW].neg;
    assign byp    = st[qrm_pkg::QW].byp;

endmodule
